@@ design/adpa_pkg.sv @@
// ----------------------------------------------------------------------------
// adpa_pkg
// Shared types and constants for the data-processing execute block.
// ----------------------------------------------------------------------------
package adpa_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REG_IDX_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Instruction field positions
  localparam int unsigned BIT_IMM   = 25;
  localparam int unsigned BIT_S     = 20;
  localparam int unsigned OPC_LSB   = 21;

  // Opcode field values
  localparam logic [3:0] OPC_AND = 4'd0;
  localparam logic [3:0] OPC_EOR = 4'd1;
  localparam logic [3:0] OPC_SUB = 4'd2;
  localparam logic [3:0] OPC_RSB = 4'd3;
  localparam logic [3:0] OPC_ADD = 4'd4;
  localparam logic [3:0] OPC_TST = 4'd8;
  localparam logic [3:0] OPC_TEQ = 4'd9;
  localparam logic [3:0] OPC_CMP = 4'd10;
  localparam logic [3:0] OPC_ORR = 4'd12;
  localparam logic [3:0] OPC_MOV = 4'd13;

  // Shift kinds
  localparam logic [1:0] SHK_LSL = 2'd0;
  localparam logic [1:0] SHK_LSR = 2'd1;
  localparam logic [1:0] SHK_ASR = 2'd2;
  localparam logic [1:0] SHK_ROR = 2'd3;

  typedef enum logic [2:0] {
    ALU_AND,
    ALU_EOR,
    ALU_SUB,
    ALU_RSB,
    ALU_ADD,
    ALU_ORR,
    ALU_MOV,
    ALU_NONE
  } alu_op_e;

  // Decoded instruction, passed from the front end to the execute side
  typedef struct packed {
    alu_op_e                alu_op;
    logic                   ok;
    logic                   wr;
    logic                   logic_op;
    logic                   set_flags;
    logic [REG_IDX_W-1:0]   rn;
    logic [REG_IDX_W-1:0]   rd;
    logic [REG_IDX_W-1:0]   rm;
    logic [REG_IDX_W-1:0]   rs;
    logic                   imm_sel;
    logic [DATA_W-1:0]      imm_val;
    logic                   imm_rot_nz;
    logic [1:0]             shift_kind;
    logic                   shift_reg;
    logic [4:0]             shamt;
  } adpa_uop_t;

  typedef struct packed {
    logic full;
    logic empty;
  } adpa_qstat_t;

endpackage

@@ design/adpa_if.sv @@
// ----------------------------------------------------------------------------
// adpa_if
// Valid/ready channels for instruction words and execute results.
// ----------------------------------------------------------------------------
interface adpa_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface adpa_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [3:0]  dest_register;
  logic        write_enable;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        unsupported;

  modport source (
    output valid, output result_value, output dest_register, output write_enable,
    output flag_n, output flag_z, output flag_c, output unsupported, input ready
  );
  modport sink (
    input valid, input result_value, input dest_register, input write_enable,
    input flag_n, input flag_z, input flag_c, input unsupported, output ready
  );
endinterface

@@ design/arm_data_processing_alu_core.sv @@
// With an empty queue, an accepted instruction is registered in the queue, then its result in the output register.
// Throughput: one instruction per cycle while the result output is not stalled; the execute stage reads operands,
//   shifts, adds and updates the register file and flags in the same cycle.
// The decode queue holds QueueDepth entries so decode and execute stall independently.
// Reset (async, rst_ni low) clears the register file, N/Z/C flags, queue and output valid.
// ----------------------------------------------------------------------------
// arm_data_processing_alu_core
// Data-processing execute block: decode front end, micro-op queue, execute.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_core
  import adpa_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  adpa_instr_if.sink    instr_i,
  adpa_result_if.source result_o
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  adpa_uop_t   push_uop, pop_uop;
  adpa_qstat_t qstat;

  adpa_front u_front (
    .instr_i      (instr_i),
    .push_valid_o (push_valid),
    .push_uop_o   (push_uop),
    .push_ready_i (push_ready)
  );

  adpa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_uop_i   (push_uop),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_uop_o    (pop_uop),
    .pop_ready_i  (pop_ready),
    .stat_o       (qstat)
  );

  adpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_uop_i   (pop_uop),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !instr_i.ready)
    else $error("instruction accepted while queue full");

  a_empty_no_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.empty |-> !pop_valid)
    else $error("execute sees work from an empty queue");

  a_unsup_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.unsupported) |-> !result_o.write_enable)
    else $error("unsupported opcode reported a register write");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=> $stable(result_o.result_value))
    else $error("result register changed while stalled");

endmodule

@@ design/adpa_front.sv @@
// ----------------------------------------------------------------------------
// adpa_front
// Accepts instruction words and decodes them into micro-ops.
// ----------------------------------------------------------------------------
module adpa_front
  import adpa_pkg::*;
(
  adpa_instr_if.sink instr_i,
  output logic       push_valid_o,
  output adpa_uop_t  push_uop_o,
  input  logic       push_ready_i
);

  logic [31:0] ins;
  logic [3:0]  opc;
  logic [4:0]  rot;
  logic [63:0] rot_pair;
  adpa_uop_t   uop;

  assign ins      = instr_i.instruction;
  assign opc      = ins[OPC_LSB +: 4];
  assign rot      = {ins[11:8], 1'b0};
  assign rot_pair = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> rot;

  always_comb begin
    uop            = '0;
    uop.alu_op     = ALU_NONE;
    uop.ok         = 1'b1;
    uop.wr         = 1'b1;
    uop.logic_op   = 1'b1;
    case (opc)
      OPC_AND: uop.alu_op = ALU_AND;
      OPC_EOR: uop.alu_op = ALU_EOR;
      OPC_SUB: begin
        uop.alu_op   = ALU_SUB;
        uop.logic_op = 1'b0;
      end
      OPC_RSB: begin
        uop.alu_op   = ALU_RSB;
        uop.logic_op = 1'b0;
      end
      OPC_ADD: begin
        uop.alu_op   = ALU_ADD;
        uop.logic_op = 1'b0;
      end
      OPC_TST: begin
        uop.alu_op = ALU_AND;
        uop.wr     = 1'b0;
      end
      OPC_TEQ: begin
        uop.alu_op = ALU_EOR;
        uop.wr     = 1'b0;
      end
      OPC_CMP: begin
        uop.alu_op   = ALU_SUB;
        uop.logic_op = 1'b0;
        uop.wr       = 1'b0;
      end
      OPC_ORR: uop.alu_op = ALU_ORR;
      OPC_MOV: uop.alu_op = ALU_MOV;
      default: begin
        uop.alu_op = ALU_NONE;
        uop.ok     = 1'b0;
        uop.wr     = 1'b0;
      end
    endcase
    uop.set_flags  = ins[BIT_S] & uop.ok;
    uop.rn         = ins[19:16];
    uop.rd         = ins[15:12];
    uop.rm         = ins[3:0];
    uop.rs         = ins[11:8];
    uop.imm_sel    = ins[BIT_IMM];
    uop.imm_val    = rot_pair[31:0];
    uop.imm_rot_nz = |ins[11:8];
    uop.shift_kind = ins[6:5];
    uop.shift_reg  = ins[4];
    uop.shamt      = ins[11:7];
  end

  assign push_valid_o  = instr_i.valid;
  assign push_uop_o    = uop;
  assign instr_i.ready = push_ready_i;

endmodule

@@ design/adpa_queue.sv @@
// ----------------------------------------------------------------------------
// adpa_queue
// Small FIFO of decoded micro-ops between decode and execute.
// ----------------------------------------------------------------------------
module adpa_queue
  import adpa_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  adpa_uop_t   push_uop_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output adpa_uop_t   pop_uop_o,
  input  logic        pop_ready_i,
  output adpa_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  adpa_uop_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_uop_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign stat_o.full  = ~push_ready_o;
  assign stat_o.empty = ~pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_uop_i;
    end
  end

endmodule

@@ design/adpa_back.sv @@
// ----------------------------------------------------------------------------
// adpa_back
// Execute side: register file, barrel shifter, ALU, flags, result register.
// ----------------------------------------------------------------------------
module adpa_back
  import adpa_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  adpa_uop_t      pop_uop_i,
  output logic           pop_ready_o,
  adpa_result_if.source  result_o
);

  logic [DATA_W-1:0] regs_q [16];
  logic              flag_n_q, flag_z_q, flag_c_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_res_q;
  logic [3:0]        out_rd_q;
  logic              out_wr_q, out_n_q, out_z_q, out_c_q, out_unsup_q;

  adpa_uop_t         u;
  logic              fire;
  logic [DATA_W-1:0] a, v, b, res;
  logic [7:0]        rs_amt, n;
  logic              sh_c, nz_c, use_nz;
  logic [DATA_W-1:0] nz_val;
  logic [32:0]       lsl_t, lsr_t, asr_t;
  logic [63:0]       ror_t;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] add_x, add_y;
  logic              add_cin;
  logic              new_n, new_z, new_c;

  assign u           = pop_uop_i;
  assign pop_ready_o = ~out_valid_q | result_o.ready;
  assign fire        = pop_valid_i & pop_ready_o;

  assign a      = regs_q[u.rn];
  assign v      = regs_q[u.rm];
  assign rs_amt = regs_q[u.rs][7:0];

  // Shift amount for the nonzero-shift path; immediate LSR/ASR #0 mean #32
  always_comb begin
    use_nz = 1'b0;
    n      = {3'd0, u.shamt};
    if (u.shift_reg) begin
      n      = rs_amt;
      use_nz = (rs_amt != 8'd0);
    end else if (u.shamt != 5'd0) begin
      use_nz = 1'b1;
    end else if (u.shift_kind == SHK_LSR || u.shift_kind == SHK_ASR) begin
      n      = 8'd32;
      use_nz = 1'b1;
    end
  end

  assign lsl_t = {1'b0, v} << n[4:0];
  assign lsr_t = {v, 1'b0} >> n[4:0];
  assign asr_t = 33'($signed({v, 1'b0}) >>> n[4:0]);
  assign ror_t = {v, v} >> n[4:0];

  always_comb begin
    nz_val = '0;
    nz_c   = 1'b0;
    case (u.shift_kind)
      SHK_LSL: begin
        if (n < 8'd32) begin
          nz_val = lsl_t[31:0];
          nz_c   = lsl_t[32];
        end else begin
          nz_c = (n == 8'd32) & v[0];
        end
      end
      SHK_LSR: begin
        if (n < 8'd32) begin
          nz_val = lsr_t[32:1];
          nz_c   = lsr_t[0];
        end else begin
          nz_c = (n == 8'd32) & v[31];
        end
      end
      SHK_ASR: begin
        if (n < 8'd32) begin
          nz_val = asr_t[32:1];
          nz_c   = asr_t[0];
        end else begin
          nz_val = {DATA_W{v[31]}};
          nz_c   = v[31];
        end
      end
      default: begin
        // multiple of 32 passes the value through; carry is bit 31 either way
        nz_val = ror_t[31:0];
        nz_c   = ror_t[31];
      end
    endcase
  end

  // Operand 2 and shifter carry
  always_comb begin
    b    = v;
    sh_c = flag_c_q;
    if (u.imm_sel) begin
      b    = u.imm_val;
      sh_c = u.imm_rot_nz ? u.imm_val[31] : flag_c_q;
    end else if (use_nz) begin
      b    = nz_val;
      sh_c = nz_c;
    end else if (!u.shift_reg && u.shift_kind == SHK_ROR) begin
      // RRX
      b    = {flag_c_q, v[31:1]};
      sh_c = v[0];
    end
  end

  // Shared adder: subtract as x + ~y + 1, carry out is the no-borrow bit
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    case (u.alu_op)
      ALU_SUB: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      ALU_RSB: begin
        add_x   = b;
        add_y   = ~a;
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end
  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};

  always_comb begin
    case (u.alu_op)
      ALU_AND:  res = a & b;
      ALU_EOR:  res = a ^ b;
      ALU_SUB:  res = sum[DATA_W-1:0];
      ALU_RSB:  res = sum[DATA_W-1:0];
      ALU_ADD:  res = sum[DATA_W-1:0];
      ALU_ORR:  res = a | b;
      ALU_MOV:  res = b;
      default:  res = '0;
    endcase
  end

  assign new_n = u.set_flags ? res[31] : flag_n_q;
  assign new_z = u.set_flags ? (res == '0) : flag_z_q;
  assign new_c = u.set_flags ? (u.logic_op ? sh_c : sum[DATA_W]) : flag_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_q[i] <= '0;
      end
      flag_n_q    <= 1'b0;
      flag_z_q    <= 1'b0;
      flag_c_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (u.wr) begin
          regs_q[u.rd] <= res;
        end
        flag_n_q <= new_n;
        flag_z_q <= new_z;
        flag_c_q <= new_c;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q   <= res;
      out_rd_q    <= u.rd;
      out_wr_q    <= u.wr;
      out_n_q     <= new_n;
      out_z_q     <= new_z;
      out_c_q     <= new_c;
      out_unsup_q <= ~u.ok;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.result_value  = out_res_q;
  assign result_o.dest_register = out_rd_q;
  assign result_o.write_enable  = out_wr_q;
  assign result_o.flag_n        = out_n_q;
  assign result_o.flag_z        = out_z_q;
  assign result_o.flag_c        = out_c_q;
  assign result_o.unsupported   = out_unsup_q;

endmodule
